FILE: rtl/core/tgc_pkg.sv
// Shared types, event codes and gesture codes for the touch gesture classifier.
package tgc_pkg;

  // Event decode
  localparam logic [4:0] EVT_KEY    = 5'd1;
  localparam logic [4:0] EVT_ABS    = 5'd3;
  localparam logic [9:0] CODE_X     = 10'd0;
  localparam logic [9:0] CODE_Y     = 10'd1;
  localparam logic [9:0] CODE_TOUCH = 10'd330;
  localparam logic [11:0] KEY_RELEASE = 12'd0;
  localparam logic [11:0] KEY_PRESS   = 12'd1;

  // Gesture codes
  localparam logic [3:0] G_NONE   = 4'd0;
  localparam logic [3:0] G_LEFT   = 4'd1;
  localparam logic [3:0] G_RIGHT  = 4'd2;
  localparam logic [3:0] G_DOWN   = 4'd3;
  localparam logic [3:0] G_UP     = 4'd4;
  localparam logic [3:0] G_TAP_BL = 4'd5;
  localparam logic [3:0] G_TAP_BR = 4'd6;
  localparam logic [3:0] G_TAP_TM = 4'd7;
  localparam logic [3:0] G_TAP_BM = 4'd8;
  localparam logic [3:0] G_TAP_TR = 4'd9;
  localparam logic [3:0] G_TAP_TL = 4'd10;

  // Reset travel threshold and its square
  localparam logic [11:0] SWIPE_DIST_RST = 12'd200;
  localparam logic [23:0] SWIPE_SQ_RST   = 24'd40000;

  // x*800/1024 = (x*25)>>5 ; y*480/600 = floor(4y/5) = (y*52432)>>16 for y < 4096
  localparam logic [4:0]  X_SCALE_MUL = 5'd25;
  localparam logic [15:0] Y_SCALE_MUL = 16'd52432;

  typedef logic signed [12:0] coord_s_t;
  typedef logic [11:0]        coord_u_t;

  typedef struct packed {
    logic [11:0] value;
    logic [9:0]  code;
    logic [4:0]  etype;
  } event_t;

  typedef struct packed {
    coord_u_t   end_y;
    coord_u_t   end_x;
    coord_s_t   start_y;
    coord_s_t   start_x;
    logic [3:0] gesture;
  } result_t;

endpackage

FILE: rtl/core/tgc_classify.sv
// Gesture decision: swipe test by squared travel, then fixed tap regions on the start point.
module tgc_classify (
  input  tgc_pkg::coord_s_t sx,
  input  tgc_pkg::coord_s_t sy,
  input  tgc_pkg::coord_u_t ex,
  input  tgc_pkg::coord_u_t ey,
  input  logic [23:0]       dist_sq,
  output logic [3:0]        gesture
);

  logic signed [13:0] dx;
  logic signed [13:0] dy;
  logic [12:0]        ax;
  logic [12:0]        ay;
  logic [25:0]        ax_sq;
  logic [25:0]        ay_sq;
  logic [26:0]        travel_sq;
  logic               is_swipe;

  function automatic logic in_box(input tgc_pkg::coord_s_t x, input tgc_pkg::coord_s_t y,
                                  input int x0, input int x1, input int y0, input int y1);
    return (x >= 13'(x0)) && (x < 13'(x1)) && (y >= 13'(y0)) && (y < 13'(y1));
  endfunction

  always_comb begin
    dx = 14'(signed'({1'b0, ex})) - 14'(sx);
    dy = 14'(signed'({1'b0, ey})) - 14'(sy);
    ax = dx[13] ? 13'(-dx) : dx[12:0];
    ay = dy[13] ? 13'(-dy) : dy[12:0];
    ax_sq = ax * ax;
    ay_sq = ay * ay;
    travel_sq = 27'(ax_sq) + 27'(ay_sq);
    is_swipe = travel_sq >= 27'(dist_sq);

    if (is_swipe && (ax > ay) && dx[13]) begin
      gesture = tgc_pkg::G_LEFT;
    end else if (is_swipe && (ax > ay)) begin
      gesture = tgc_pkg::G_RIGHT;
    end else if (is_swipe && (ay > ax) && !dy[13]) begin
      gesture = tgc_pkg::G_DOWN;
    end else if (is_swipe && (ay > ax)) begin
      gesture = tgc_pkg::G_UP;
    end else if (in_box(sx, sy, 0, 200, 280, 480)) begin
      gesture = tgc_pkg::G_TAP_BL;
    end else if (in_box(sx, sy, 600, 800, 280, 480)) begin
      gesture = tgc_pkg::G_TAP_BR;
    end else if (in_box(sx, sy, 300, 500, 0, 200)) begin
      gesture = tgc_pkg::G_TAP_TM;
    end else if (in_box(sx, sy, 300, 500, 380, 480)) begin
      gesture = tgc_pkg::G_TAP_BM;
    end else if (in_box(sx, sy, 700, 800, 0, 100)) begin
      gesture = tgc_pkg::G_TAP_TR;
    end else if (in_box(sx, sy, 0, 100, 0, 100)) begin
      gesture = tgc_pkg::G_TAP_TL;
    end else begin
      gesture = tgc_pkg::G_NONE;
    end
  end

endmodule

FILE: rtl/core/touch_gesture_classifier.sv
// Top level of the touch gesture classifier: event register, state update, result register.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------------------
//  in_     | in  | in_tvalid/in_tready   | in_tdata: event_type, event_code, event_value
//  out_    | out | out_tvalid/out_tready | out_tdata: gesture, start_x/y, end_x/y
//  cfg_    | in  | cfg_valid/cfg_ready   | cfg_data: swipe_distance (squared on write)
//
// One beat per cycle in while no release is held by the output; the event register loads at
// the accepting edge, and a release in it then loads the result register, which drives
// out_tvalid. Throughput is one event per cycle, set by the single decode/classify stage,
// except while a release stalls. Reset (rst_n low, synchronous) clears position state to
// zero, the start point to -1 and the threshold to 200. A stalled out_tready holds the result
// register and, with a release waiting in the event register, backs up into it and in_tready.
module touch_gesture_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [4:0] event_type, [14:5] event_code, [26:15] event_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [3:0] gesture, [16:4] start_x, [29:17] start_y,
                                  // [41:30] end_x, [53:42] end_y
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data
);

  tgc_pkg::event_t    ev_r;
  logic               ev_valid_r;
  logic               ev_valid_nxt;
  tgc_pkg::coord_u_t  latest_x_r, latest_x_nxt;
  tgc_pkg::coord_u_t  latest_y_r, latest_y_nxt;
  tgc_pkg::coord_s_t  press_x_r, press_x_nxt;
  tgc_pkg::coord_s_t  press_y_r, press_y_nxt;
  logic [23:0]        dist_sq_r, dist_sq_nxt;
  tgc_pkg::result_t   res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               is_abs;
  logic               is_touch;
  logic               is_release;
  logic               out_free;
  logic               ev_fire;
  logic [16:0]        x_prod;
  logic [27:0]        y_prod;
  logic [3:0]         gesture;

  assign is_abs     = ev_r.etype == tgc_pkg::EVT_ABS;
  assign is_touch   = (ev_r.etype == tgc_pkg::EVT_KEY) && (ev_r.code == tgc_pkg::CODE_TOUCH);
  assign is_release = is_touch && (ev_r.value == tgc_pkg::KEY_RELEASE);
  assign out_free   = !out_valid_r || out_tready;
  assign ev_fire    = ev_valid_r && (!is_release || out_free);
  assign in_tready  = !ev_valid_r || ev_fire;
  assign cfg_ready  = 1'b1;

  assign x_prod = ev_r.value * tgc_pkg::X_SCALE_MUL;
  assign y_prod = ev_r.value * tgc_pkg::Y_SCALE_MUL;

  tgc_classify u_classify (
    .sx      (press_x_r),
    .sy      (press_y_r),
    .ex      (latest_x_r),
    .ey      (latest_y_r),
    .dist_sq (dist_sq_r),
    .gesture (gesture)
  );

  always_comb begin
    ev_valid_nxt  = ev_valid_r;
    latest_x_nxt  = latest_x_r;
    latest_y_nxt  = latest_y_r;
    press_x_nxt   = press_x_r;
    press_y_nxt   = press_y_r;
    dist_sq_nxt   = dist_sq_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;

    if (cfg_valid) begin
      dist_sq_nxt = cfg_data * cfg_data;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (ev_fire) begin
      if (is_abs && (ev_r.code == tgc_pkg::CODE_X)) begin
        latest_x_nxt = x_prod[16:5];
      end else if (is_abs && (ev_r.code == tgc_pkg::CODE_Y)) begin
        latest_y_nxt = y_prod[27:16];
      end else if (is_touch && (ev_r.value == tgc_pkg::KEY_PRESS)) begin
        press_x_nxt = 13'(signed'({1'b0, latest_x_r}));
        press_y_nxt = 13'(signed'({1'b0, latest_y_r}));
      end else if (is_release) begin
        res_nxt.gesture = gesture;
        res_nxt.start_x = press_x_r;
        res_nxt.start_y = press_y_r;
        res_nxt.end_x   = latest_x_r;
        res_nxt.end_y   = latest_y_r;
        out_valid_nxt   = 1'b1;
        // drop the start point once the gesture is loaded into the result register
        press_x_nxt     = '1;
        press_y_nxt     = '1;
      end
    end

    if (in_tvalid && in_tready) begin
      ev_valid_nxt = 1'b1;
    end else if (ev_fire) begin
      ev_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      latest_x_r  <= '0;
      latest_y_r  <= '0;
      press_x_r   <= '1;
      press_y_r   <= '1;
      dist_sq_r   <= tgc_pkg::SWIPE_SQ_RST;
    end else begin
      ev_valid_r  <= ev_valid_nxt;
      out_valid_r <= out_valid_nxt;
      latest_x_r  <= latest_x_nxt;
      latest_y_r  <= latest_y_nxt;
      press_x_r   <= press_x_nxt;
      press_y_r   <= press_y_nxt;
      dist_sq_r   <= dist_sq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ev_r <= in_tdata[26:0];
    end
    res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r};

endmodule
